>>> rtl/mmss_pkg.sv
// Package for the small-secret matrix multiply-subtract block.
// Holds request/result types, command and register codes, field widths and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmss_pkg;

    localparam int CMD_W      = 2;
    localparam int INNER_W    = 10;
    localparam int COL_W      = 4;
    localparam int DATA_W     = 16;
    localparam int ROWCNT_W   = 13;
    localparam int INLEN_W    = 11;
    localparam int COLUSE_W   = 5;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int ROWCTR_W   = 12;
    localparam int LIMIT_W    = 13;
    localparam int COLLIM_W   = 7;

    localparam int DEF_MAX_INNER   = 1024;
    localparam int DEF_MAX_COLUMNS = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAC     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMBINE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS      = 2'd2;

    localparam logic [ROWCNT_W-1:0] RST_ROW_COUNT = 13'd1024;
    localparam logic [INLEN_W-1:0]  RST_INNER_LEN = 11'd1024;
    localparam logic [COLUSE_W-1:0] RST_COLS      = 5'd8;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INNER_W-1:0] inner_index;
        logic [COL_W-1:0]   column_index;
        logic [DATA_W-1:0]  data_value;
    } t_in_req;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic [COL_W-1:0]  result_column;
        logic              last_of_matrix;
    } t_out_res;

    typedef struct packed {
        logic mac_en;
        logic comb_en;
    } t_acc_ctl;

endpackage

`default_nettype wire

>>> rtl/mmss_sram.sv
// Secret store: one row per inner index, one byte lane per column.
// Byte-lane write, full-row registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmss_sram #(
    parameter int DEPTH = 1024,
    parameter int LANES = 16,
    parameter int AW    = 10,
    parameter int CW    = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [CW-1:0]         i_wlane,
    input  wire logic [7:0]            i_wbyte,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic [LANES-1:0][7:0]      o_rdata
);

    logic [LANES-1:0][7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][i_wlane] <= i_wbyte;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/mmss_acc.sv
// Column sum lanes, row counter and combine arithmetic.
// Depends on mmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmss_acc #(
    parameter int LANES = 16,
    parameter int CW    = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mmss_pkg::t_acc_ctl                 i_ctl,
    input  wire logic [mmss_pkg::DATA_W-1:0]        i_data,
    input  wire logic [CW-1:0]                      i_col,
    input  wire logic [mmss_pkg::COLLIM_W-1:0]      i_cols,
    input  wire logic                               i_col_last,
    input  wire logic [mmss_pkg::ROWCTR_W-1:0]      i_row_last_idx,
    input  wire logic [LANES-1:0][7:0]              i_row,
    output logic [mmss_pkg::DATA_W-1:0]             o_value,
    output logic                                    o_last
);
    import mmss_pkg::*;

    logic [DATA_W-1:0]   r_sum [LANES];
    logic [DATA_W-1:0]   n_sum [LANES];
    logic [ROWCTR_W-1:0] r_row_cnt;
    logic [ROWCTR_W-1:0] n_row_cnt;
    logic [DATA_W-1:0]   w_prod [LANES];
    logic                w_last_row;

    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            w_prod[c] = i_data * {{8{i_row[c][7]}}, i_row[c]};
        end
    end

    assign w_last_row = (r_row_cnt == i_row_last_idx);
    assign o_last     = i_col_last && w_last_row;
    assign o_value    = i_data - r_sum[i_col];

    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            n_sum[c] = r_sum[c];
            if (i_ctl.mac_en && (COLLIM_W'(c) < i_cols)) begin
                n_sum[c] = r_sum[c] + w_prod[c];
            end
        end
        if (i_ctl.comb_en) begin
            n_sum[i_col] = '0;
        end
        n_row_cnt = r_row_cnt;
        if (i_ctl.comb_en && i_col_last) begin
            n_row_cnt = w_last_row ? '0 : r_row_cnt + ROWCTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < LANES; c++) begin
                r_sum[c] <= '0;
            end
            r_row_cnt <= '0;
        end else begin
            for (int c = 0; c < LANES; c++) begin
                r_sum[c] <= n_sum[c];
            end
            r_row_cnt <= n_row_cnt;
        end
    end

    a_wrap_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.comb_en && o_last) |=> (r_row_cnt == '0))
        else $error("row counter did not wrap after last row");

    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.comb_en && !i_col_last && !i_ctl.mac_en) |=> $stable(r_row_cnt))
        else $error("row counter moved before last column");

endmodule

`default_nettype wire

>>> rtl/matrix_mul_small_secret_sub.sv
// Top level of the small-secret matrix multiply-subtract block: out = out - A*S mod 2^16.
// Depends on mmss_pkg, mmss_sram and mmss_acc.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req) carries requests:
//     load a signed secret byte, stream a matrix element of the current row,
//     or combine an out element with its column sum.
//   Output channel (o_out_valid / i_out_stall / o_out_res) returns one result
//     for each combine request whose column is in use; other requests give none.
//   Configuration writes (i_cfg_wr_en, i_cfg_index, i_cfg_wdata) take effect at
//     once and belong to idle periods only.
//   Pipeline: an accepted request moves through the stage registers r_a and r_b,
//     and a combine result then into the output register r_o; a stall can hold it.
//   Throughput: one request per cycle while o_in_stall is low; the secret row read and all column
//     multiply-accumulates happen in a single pass per stage.
//   Reset: clears column sums, row counter, pipeline valids and sets the
//     configuration to 1024 rows, 1024 inner length, 8 columns. The secret
//     store is not cleared and must be loaded before use.
//   Receiver stall: the result holds in the output register; the pipeline keeps
//     accepting requests while free stages remain and stalls the input
//     only when every stage is occupied behind the waiting result.
`timescale 1ns / 1ps
`default_nettype none

module matrix_mul_small_secret_sub #(
    parameter int MAX_INNER   = mmss_pkg::DEF_MAX_INNER,
    parameter int MAX_COLUMNS = mmss_pkg::DEF_MAX_COLUMNS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire mmss_pkg::t_in_req                  i_in_req,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output mmss_pkg::t_out_res                      o_out_res,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [mmss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mmss_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import mmss_pkg::*;

    localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [ROWCNT_W-1:0] r_row_count;
    logic [INLEN_W-1:0]  r_inner_len;
    logic [COLUSE_W-1:0] r_cols;

    logic [LIMIT_W-1:0]  w_inner_lim;
    logic [COLLIM_W-1:0] w_col_lim;
    logic [ROWCTR_W-1:0] w_row_last_idx;

    logic                r_a_v;
    t_in_req             r_a;
    logic                r_b_v;
    t_in_req             r_b;
    logic                r_o_v;
    t_out_res            r_o;

    logic                w_a_inner_ok;
    logic                w_a_col_ok;
    logic                w_b_inner_ok;
    logic                w_b_col_ok;
    logic                w_b_res;
    logic                w_b_adv;
    logic                w_b_free;
    logic                w_a_adv;
    logic                w_in_acc;
    logic                w_ram_we;
    logic                w_ram_re;
    logic [MAX_COLUMNS-1:0][7:0] w_row;
    t_acc_ctl            w_ctl;
    logic [DATA_W-1:0]   w_value;
    logic                w_last;
    logic [CW-1:0]       w_b_col;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= RST_ROW_COUNT;
            r_inner_len <= RST_INNER_LEN;
            r_cols      <= RST_COLS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ROW_COUNT: r_row_count <= i_cfg_wdata[ROWCNT_W-1:0];
                REG_INNER_LEN: r_inner_len <= i_cfg_wdata[INLEN_W-1:0];
                REG_COLS:      r_cols      <= i_cfg_wdata[COLUSE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_inner_lim = (LIMIT_W'(r_inner_len) > LIMIT_W'(MAX_INNER))
                         ? LIMIT_W'(MAX_INNER) : LIMIT_W'(r_inner_len);
    assign w_col_lim   = (COLLIM_W'(r_cols) > COLLIM_W'(MAX_COLUMNS))
                         ? COLLIM_W'(MAX_COLUMNS) : COLLIM_W'(r_cols);

    always_comb begin
        priority if (r_row_count == '0) begin
            w_row_last_idx = '0;
        end else if (r_row_count > ROWCNT_W'(4096)) begin
            w_row_last_idx = '1;
        end else begin
            w_row_last_idx = ROWCTR_W'(r_row_count - ROWCNT_W'(1));
        end
    end

    // Handshake and stage control
    assign w_a_inner_ok = LIMIT_W'(r_a.inner_index) < w_inner_lim;
    assign w_a_col_ok   = COLLIM_W'(r_a.column_index) < w_col_lim;
    assign w_b_inner_ok = LIMIT_W'(r_b.inner_index) < w_inner_lim;
    assign w_b_col_ok   = COLLIM_W'(r_b.column_index) < w_col_lim;

    assign w_b_res  = r_b_v && (r_b.cmd == CMD_COMBINE) && w_b_col_ok;
    assign w_b_adv  = r_b_v && (!w_b_res || !r_o_v || !i_out_stall);
    assign w_b_free = !r_b_v || w_b_adv;
    assign w_a_adv  = r_a_v && w_b_free;

    assign o_in_stall = r_a_v && !w_b_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_ram_we = w_a_adv && (r_a.cmd == CMD_LOAD) && w_a_inner_ok && w_a_col_ok;
    assign w_ram_re = w_a_adv && (r_a.cmd == CMD_MAC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_a_v <= 1'b1;
            end else if (w_a_adv) begin
                r_a_v <= 1'b0;
            end
            if (w_b_free) begin
                r_b_v <= w_a_adv;
            end
            if (w_b_adv && w_b_res) begin
                r_o_v <= 1'b1;
            end else if (r_o_v && !i_out_stall) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a <= i_in_req;
        end
        if (w_b_free) begin
            r_b <= r_a;
        end
        if (w_b_adv && w_b_res) begin
            r_o.result_value   <= w_value;
            r_o.result_column  <= r_b.column_index;
            r_o.last_of_matrix <= w_last;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_res   = r_o;

    mmss_sram #(
        .DEPTH (MAX_INNER),
        .LANES (MAX_COLUMNS),
        .AW    (AW),
        .CW    (CW)
    ) u_sram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(r_a.inner_index)),
        .i_wlane (CW'(r_a.column_index)),
        .i_wbyte (r_a.data_value[7:0]),
        .i_re    (w_ram_re),
        .i_raddr (AW'(r_a.inner_index)),
        .o_rdata (w_row)
    );

    assign w_ctl.mac_en  = w_b_adv && (r_b.cmd == CMD_MAC) && w_b_inner_ok;
    assign w_ctl.comb_en = w_b_adv && w_b_res;
    assign w_b_col       = CW'(r_b.column_index);

    mmss_acc #(
        .LANES (MAX_COLUMNS),
        .CW    (CW)
    ) u_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_data         (r_b.data_value),
        .i_col          (w_b_col),
        .i_cols         (w_col_lim),
        .i_col_last     (COLLIM_W'(r_b.column_index) == w_col_lim - COLLIM_W'(1)),
        .i_row_last_idx (w_row_last_idx),
        .i_row          (w_row),
        .o_value        (w_value),
        .o_last         (w_last)
    );

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_v && r_b_v && r_o_v))
        else $error("input stalled with a free stage");

    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("secret store written and read in one cycle");

    a_res_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_adv && w_b_res) |=> r_o_v)
        else $error("combine result lost");

endmodule

`default_nettype wire
